>>> rtl/core/f2d_pkg.sv
// ----------------------------------------------------------------------------
// f2d_pkg
// shared types and constants for the float to decimal text converter
// ----------------------------------------------------------------------------
package f2d_pkg;

    localparam int MAX_FRACTION_DIGITS = 7;
    localparam int AUTO_FIELD_WIDTH    = 14;
    localparam int EXP_BIAS            = 127;
    localparam int EXP_MIN             = -23;
    localparam int EXP_MAX             = 30;
    localparam int FRAC_W              = 24;
    localparam int INT_W               = 31;
    localparam int INT_DIGITS          = 10;
    localparam int QUOT_W              = 28;
    localparam int RECIP_SHIFT         = 35;
    localparam int SHIFT_W             = 77;

    localparam logic [7:0]  EXP_LO     = 8'(EXP_BIAS + EXP_MIN - 1 + 1);
    localparam logic [7:0]  EXP_HI     = 8'(EXP_BIAS + EXP_MAX);
    localparam logic [7:0]  SHIFT_BASE = 8'(EXP_BIAS + EXP_MIN);
    localparam logic [31:0] RECIP_TEN  = 32'hCCCC_CCCD;
    localparam logic [31:0] TEN        = 32'd10;

    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_MINUS = 7'h2D;
    localparam logic [6:0] CHAR_DOT   = 7'h2E;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_MUL,
        S_DIV_SUB,
        S_FRAC_MUL,
        S_FRAC_TAKE,
        S_SIGN,
        S_INT,
        S_DOT,
        S_FRAC_OUT
    } t_state;

    typedef enum logic {
        OP_DIV10,
        OP_TIMES10
    } t_mul_op;

    typedef struct packed {
        logic [QUOT_W-1:0] quot;
        logic [3:0]        digit;
        logic [FRAC_W-1:0] frac;
    } t_step_res;

endpackage

>>> rtl/core/f2d_mul_unit.sv
// ----------------------------------------------------------------------------
// f2d_mul_unit
// shared multiplier: divide by ten through a reciprocal, or times ten
// ----------------------------------------------------------------------------
module f2d_mul_unit
    import f2d_pkg::*;
(
    input  logic        i_clk,
    input  t_mul_op     i_op,
    input  logic [31:0] i_operand,
    output t_step_res   o_res
);

    logic [63:0] r_prod;
    logic [3:0]  r_opnd_lo;
    t_mul_op     r_op;
    logic [31:0] mul_b;
    logic [3:0]  q_lo;
    logic [3:0]  rem;

    assign mul_b = (i_op == OP_DIV10) ? RECIP_TEN : TEN;

    always_ff @(posedge i_clk) begin
        r_prod    <= 64'(i_operand) * 64'(mul_b);
        r_opnd_lo <= i_operand[3:0];
        r_op      <= i_op;
    end

    always_comb begin
        o_res.quot = r_prod[RECIP_SHIFT +: QUOT_W];
        q_lo       = r_prod[RECIP_SHIFT +: 4];
        // remainder is below ten, so the low four bits settle it
        rem        = r_opnd_lo - 4'({q_lo, 3'b000} + {1'b0, q_lo, 1'b0});
        o_res.frac = r_prod[FRAC_W-1:0];
        case (r_op)
            OP_DIV10:   o_res.digit = rem;
            OP_TIMES10: o_res.digit = r_prod[FRAC_W +: 4];
            default:    o_res.digit = rem;
        endcase
    end

endmodule

>>> rtl/core/float_to_decimal_string_unit.sv
// ----------------------------------------------------------------------------
// float_to_decimal_string_unit
// converts a float word to decimal ascii text, one character per beat
// ----------------------------------------------------------------------------
//  channel  signals                          beat
//  in       i_in_valid / o_in_ready          i_raw_word
//  out      o_out_valid / i_out_ready        o_character, o_last
//  cfg      i_cfg_we                         i_cfg_data (fraction digit limit)
//
//  a word is split into integer digits by divide-by-ten steps and into
//  fraction digits by times-ten steps on the shared multiplier, each step
//  a multiply state and a state that takes the digit, before its text is sent.
//  o_in_ready is high only between words; characters leave through an
//  output register, so a stall on the output only holds the sequencer
//  reset is synchronous, active low, and clears the sequencer and register
// ----------------------------------------------------------------------------
module float_to_decimal_string_unit
    import f2d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_raw_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [6:0]  o_character,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_data
);

    t_state r_state, n_state;

    logic [2:0]        r_cfg;
    logic              r_sign, n_sign;
    logic [INT_W-1:0]  r_x, n_x;
    logic [FRAC_W-1:0] r_frac, n_frac;
    logic [3:0]        r_icnt, n_icnt;
    logic [2:0]        r_fcnt, n_fcnt;
    logic [2:0]        r_flen, n_flen;
    logic [3:0]        r_idig [INT_DIGITS];
    logic [3:0]        r_fdig [MAX_FRACTION_DIGITS];
    logic              r_ovalid;
    logic [6:0]        r_ochar;
    logic              r_olast;

    logic              accept;
    logic              o_free;
    logic              emit;
    logic              fire;
    logic [6:0]        e_char;
    logic              e_last;
    t_mul_op           mul_op;
    logic [31:0]       mul_operand;
    t_step_res         step;
    logic [2:0]        goal;
    logic              frac_done;
    logic              in_range;
    logic [7:0]        exp_b;
    logic [5:0]        sh_amt;
    logic [SHIFT_W-1:0] shifted;
    logic              dec_sign;
    logic [INT_W-1:0]  dec_x;
    logic [FRAC_W-1:0] dec_frac;
    t_state            after_int;
    t_state            after_calc;

    function automatic logic [2:0] frac_count(input logic sign, input logic [3:0] icnt,
                                              input logic [2:0] cfg);
        logic [4:0] lead;
        logic [4:0] cnt;
        lead = 5'(sign) + ((icnt == 4'd0) ? 5'd1 : 5'(icnt)) + 5'd1;
        if (cfg != 3'd0) begin
            cnt = 5'(cfg);
        end else if (lead >= 5'(AUTO_FIELD_WIDTH)) begin
            cnt = 5'd1;
        end else begin
            cnt = 5'(AUTO_FIELD_WIDTH) - lead;
        end
        if (cnt > 5'(MAX_FRACTION_DIGITS)) begin
            cnt = 5'(MAX_FRACTION_DIGITS);
        end
        return cnt[2:0];
    endfunction

    f2d_mul_unit u_mul (
        .i_clk     (i_clk),
        .i_op      (mul_op),
        .i_operand (mul_operand),
        .o_res     (step)
    );

    // decode of the incoming word
    assign exp_b    = i_raw_word[31:24];
    assign in_range = (exp_b >= EXP_LO) && (exp_b <= EXP_HI);
    assign sh_amt   = 6'(exp_b - SHIFT_BASE);
    assign shifted  = {53'd0, 1'b1, i_raw_word[22:0]} << sh_amt;
    assign dec_sign = in_range & i_raw_word[23];
    assign dec_x    = in_range ? shifted[SHIFT_W-1 -: INT_W] : '0;
    assign dec_frac = in_range ? shifted[SHIFT_W-INT_W-1 -: FRAC_W] : '0;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid & o_in_ready;
    assign o_free      = !r_ovalid || i_out_ready;
    assign fire        = emit & o_free;
    assign goal        = frac_count(r_sign, r_icnt, r_cfg);
    assign frac_done   = ({1'b0, r_fcnt} + 4'd1) == {1'b0, goal};
    assign after_int   = r_sign ? S_SIGN : S_INT;
    assign after_calc  = (r_frac != '0) ? S_FRAC_MUL : after_int;

    assign o_out_valid = r_ovalid;
    assign o_character = r_ochar;
    assign o_last      = r_olast;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (dec_x != '0) begin
                        n_state = S_DIV_MUL;
                    end else if (dec_frac != '0) begin
                        n_state = S_FRAC_MUL;
                    end else begin
                        n_state = dec_sign ? S_SIGN : S_INT;
                    end
                end
            end
            S_DIV_MUL: n_state = S_DIV_SUB;
            S_DIV_SUB: begin
                n_state = (step.quot != '0) ? S_DIV_MUL : after_calc;
            end
            S_FRAC_MUL: n_state = S_FRAC_TAKE;
            S_FRAC_TAKE: begin
                n_state = frac_done ? after_int : S_FRAC_MUL;
            end
            S_SIGN: begin
                if (fire) n_state = S_INT;
            end
            S_INT: begin
                if (fire && r_icnt <= 4'd1) n_state = S_DOT;
            end
            S_DOT: begin
                if (fire) n_state = S_FRAC_OUT;
            end
            S_FRAC_OUT: begin
                if (fire && e_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        emit        = 1'b0;
        e_char      = CHAR_ZERO;
        e_last      = 1'b0;
        mul_op      = OP_DIV10;
        mul_operand = {1'b0, r_x};
        unique case (r_state)
            S_DIV_MUL: begin
                mul_op      = OP_DIV10;
                mul_operand = {1'b0, r_x};
            end
            S_FRAC_MUL: begin
                mul_op      = OP_TIMES10;
                mul_operand = {8'd0, r_frac};
            end
            S_SIGN: begin
                emit   = 1'b1;
                e_char = CHAR_MINUS;
            end
            S_INT: begin
                emit   = 1'b1;
                e_char = (r_icnt == 4'd0) ? CHAR_ZERO
                                          : CHAR_ZERO + 7'(r_idig[r_icnt - 4'd1]);
            end
            S_DOT: begin
                emit   = 1'b1;
                e_char = CHAR_DOT;
            end
            S_FRAC_OUT: begin
                emit   = 1'b1;
                e_char = CHAR_ZERO + 7'(r_fdig[r_fcnt]);
                e_last = ({1'b0, r_fcnt} + 4'd1) == {1'b0, r_flen};
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_sign = r_sign;
        n_x    = r_x;
        n_frac = r_frac;
        n_icnt = r_icnt;
        n_fcnt = r_fcnt;
        n_flen = r_flen;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_sign = dec_sign;
                    n_x    = dec_x;
                    n_frac = dec_frac;
                    n_icnt = 4'd0;
                    n_fcnt = 3'd0;
                    n_flen = 3'd1;
                end
            end
            S_DIV_SUB: begin
                n_x    = INT_W'(step.quot);
                n_icnt = r_icnt + 4'd1;
            end
            S_FRAC_TAKE: begin
                n_frac = step.frac;
                n_fcnt = r_fcnt + 3'd1;
                if (step.digit != 4'd0) n_flen = r_fcnt + 3'd1;
            end
            S_INT: begin
                if (fire && r_icnt > 4'd1) n_icnt = r_icnt - 4'd1;
            end
            S_DOT: begin
                n_fcnt = 3'd0;
            end
            S_FRAC_OUT: begin
                if (fire) n_fcnt = r_fcnt + 3'd1;
            end
            default: begin
                n_x = r_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cfg    <= 3'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_cfg <= i_cfg_data;
            if (fire) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sign <= n_sign;
        r_x    <= n_x;
        r_frac <= n_frac;
        r_icnt <= n_icnt;
        r_fcnt <= n_fcnt;
        r_flen <= n_flen;
        if (fire) begin
            r_ochar <= e_char;
            r_olast <= e_last;
        end
        // a zero fraction reads back as a single zero digit
        if (accept) r_fdig[0] <= 4'd0;
        if (r_state == S_DIV_SUB) r_idig[r_icnt] <= step.digit;
        if (r_state == S_FRAC_TAKE) r_fdig[r_fcnt] <= step.digit;
    end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// float word to decimal text converter, checked character by character
// ----------------------------------------------------------------------------
// a short table of hand-picked words (range limits, signs, exact values,
// trimming) is walked under several fraction digit limits, followed by
// random words in phases with different limits. every accepted word is
// turned into its expected text by a local model of the conversion, or by
// the text typed into the table, and each output beat is compared with the
// oldest expected character. both channels idle at random except in one
// phase, and the sender drains the converter before every limit change.
// ----------------------------------------------------------------------------
module tb_top
    import f2d_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [6:0] character;
        logic       last;
    } t_char_beat;

    typedef struct {
        logic [2:0]  fdig;
        logic [31:0] word;
        string       text;
    } t_word_row;

    localparam int N_ROWS   = 23;
    localparam int N_PHASES = 8;
    localparam int N_RANDOM = 56;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [31:0] i_raw_word;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [6:0]  o_character;
    logic        o_last;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_data;

    t_char_beat  expected_chars[$];
    logic [2:0]  fdig_now;
    string       typed_text;
    bit          calm;
    int          n_fail;

    t_word_row word_table[N_ROWS] = '{
        '{3'd0, 32'h0000_0000, "0.0"},
        '{3'd0, 32'hFFFF_FFFF, "0.0"},
        '{3'd0, 32'h9E00_0000, "0.0"},
        '{3'd0, 32'h67FF_FFFF, "0.0"},
        '{3'd0, 32'h9DFF_FFFF, "-2147483520.0"},
        '{3'd0, 32'h9D00_0000, ""},
        '{3'd0, 32'h7F00_0000, "1.0"},
        '{3'd0, 32'h7F80_0000, "-1.0"},
        '{3'd0, 32'h7E00_0000, "0.5"},
        '{3'd0, 32'h6800_0000, ""},
        '{3'd0, 32'h68FF_FFFF, ""},
        '{3'd0, 32'h95FF_FFFF, ""},
        '{3'd0, 32'h9600_0001, ""},
        '{3'd0, 32'h8049_0FDB, ""},
        '{3'd0, 32'h8AC0_0000, ""},
        '{3'd0, 32'h7D7F_FFFF, ""},
        '{3'd7, 32'h7E2A_AAAB, ""},
        '{3'd7, 32'h9D7F_FFFF, ""},
        '{3'd1, 32'h6800_0000, "0.0"},
        '{3'd1, 32'h7E2A_AAAB, ""},
        '{3'd1, 32'h7FC0_0000, "-1.5"},
        '{3'd3, 32'h8049_0FDB, ""},
        '{3'd3, 32'h7B4C_CCCD, ""}
    };

    logic [2:0] phase_fdig[N_PHASES] = '{3'd0, 3'd7, 3'd2, 3'd1, 3'd5, 3'd4, 3'd6, 3'd0};

    float_to_decimal_string_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_raw_word  (i_raw_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_character (o_character),
        .o_last      (o_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(5_000_000);
        $display("tb_top failed");
        $finish;
    end

    function automatic void predict_text(input logic [31:0] raw, input logic [2:0] fdig);
        logic [6:0]  txt[24];
        logic [6:0]  rev[12];
        logic [23:0] mant;
        logic [23:0] low;
        logic [31:0] ipart;
        logic [27:0] frac;
        int          e;
        int          len;
        int          nd;
        int          count;
        len   = 0;
        ipart = '0;
        frac  = '0;
        e     = int'(raw[31:24]) - EXP_BIAS;
        if (e > EXP_MAX || e < EXP_MIN || raw == 32'd0) begin
            txt[0] = CHAR_ZERO;
            txt[1] = CHAR_DOT;
            txt[2] = CHAR_ZERO;
            len    = 3;
        end else begin
            mant = {1'b1, raw[22:0]};
            if (e >= 23) begin
                ipart = {8'd0, mant} << (e - 23);
            end else if (e >= 0) begin
                ipart = {8'd0, mant >> (23 - e)};
                low   = mant << (e + 1);
                frac  = {4'd0, low};
            end else begin
                low  = mant >> (-(e + 1));
                frac = {4'd0, low};
            end
            if (raw[23]) begin
                txt[len] = CHAR_MINUS;
                len++;
            end
            if (ipart == 0) begin
                txt[len] = CHAR_ZERO;
                len++;
            end else begin
                nd = 0;
                while (ipart != 0) begin
                    rev[nd] = CHAR_ZERO + 7'(ipart % 10);
                    ipart   = ipart / 10;
                    nd++;
                end
                while (nd > 0) begin
                    nd--;
                    txt[len] = rev[nd];
                    len++;
                end
            end
            txt[len] = CHAR_DOT;
            len++;
            if (frac == 0) begin
                txt[len] = CHAR_ZERO;
                len++;
            end else begin
                if (fdig != 0) begin
                    count = int'(fdig);
                end else if (len >= AUTO_FIELD_WIDTH) begin
                    count = 1;
                end else begin
                    count = AUTO_FIELD_WIDTH - len;
                end
                if (count > MAX_FRACTION_DIGITS) count = MAX_FRACTION_DIGITS;
                if (count < 1) count = 1;
                repeat (count) begin
                    frac         = frac * 28'd10;
                    txt[len]     = CHAR_ZERO + 7'(frac[27:24]);
                    frac[27:24]  = 4'd0;
                    len++;
                end
                while (txt[len-1] == CHAR_ZERO && txt[len-2] != CHAR_DOT) len--;
            end
        end
        for (int k = 0; k < len; k++) begin
            expected_chars.push_back('{character: txt[k], last: (k == len - 1)});
        end
    endfunction

    // expectations are queued at the accepting edge, before any output check
    always @(posedge i_clk) begin
        t_char_beat want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                if (typed_text.len() > 0) begin
                    for (int k = 0; k < typed_text.len(); k++) begin
                        expected_chars.push_back('{character: 7'(typed_text[k]),
                                                   last: (k == typed_text.len() - 1)});
                    end
                end else begin
                    predict_text(i_raw_word, fdig_now);
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_chars.size() == 0) begin
                    $error("character: no beat expected, got %h", o_character);
                    n_fail++;
                end else begin
                    want = expected_chars.pop_front();
                    if (o_character !== want.character) begin
                        $error("character: expected %h, got %h", want.character, o_character);
                        n_fail++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %b, got %b", want.last, o_last);
                        n_fail++;
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(0, 99) >= 38);
    end

    // entered at a falling edge, returns at the falling edge after the beat
    task automatic send_word(input logic [31:0] raw, input string txt);
        while (!calm && $urandom_range(0, 99) < 38) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        typed_text = txt;
        i_in_valid <= 1'b1;
        i_raw_word <= raw;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic drain_text();
        i_in_valid <= 1'b0;
        while (expected_chars.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_fraction_digits(input logic [2:0] value);
        drain_text();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        fdig_now = value;
    endtask

    function automatic logic [31:0] random_word();
        logic [31:0] w;
        int          pick;
        w    = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            w[31:24] = 8'($urandom_range(104, 157));
        end else if (pick < 80) begin
            w[31:24] = 8'($urandom_range(120, 133));
            w[15:0]  = 16'd0;
        end else if (pick < 86) begin
            w[31:24] = $urandom_range(0, 1) ? 8'd103 : 8'd158;
        end else if (pick < 88) begin
            w = 32'd0;
        end
        return w;
    endfunction

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_raw_word  = '0;
        i_out_ready = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        fdig_now    = '0;
        typed_text  = "";
        calm        = 1'b0;
        n_fail      = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (word_table[r]) begin
            if (word_table[r].fdig != fdig_now) set_fraction_digits(word_table[r].fdig);
            send_word(word_table[r].word, word_table[r].text);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            set_fraction_digits(phase_fdig[p]);
            calm = (p == 3);
            for (int n = 0; n < N_RANDOM; n++) begin
                if ($urandom_range(0, 39) == 0) drain_text();
                send_word(random_word(), "");
            end
        end
        calm = 1'b0;

        drain_text();
        repeat (60) @(negedge i_clk);
        if (n_fail == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/f2d_pkg.sv
rtl/core/f2d_mul_unit.sv
rtl/core/float_to_decimal_string_unit.sv
tb/tb_top.sv
